### src/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg - shared types for the mac sync table
// Key widths and the flag store update commands.
// ----------------------------------------------------------------------------
package rmst_pkg;

  localparam int unsigned MAC_W  = 48;
  localparam int unsigned VLAN_W = 12;
  localparam int unsigned KEY_W  = MAC_W + VLAN_W;

  // update applied to the per-slot flags
  typedef enum logic [2:0] {
    FL_NONE,
    FL_CREATE,
    FL_MARK_ADD,
    FL_MARK_REM,
    FL_DELETE,
    FL_SYNCED,
    FL_PURGE
  } flag_cmd_e;

endpackage

### src/rmst_ram.sv
// ----------------------------------------------------------------------------
// rmst_ram - generic single write, single read ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### src/rmst_flags.sv
// ----------------------------------------------------------------------------
// rmst_flags - per-slot valid, removing and synced flags
// Flip-flop store cleared by reset, updated by one command a cycle.
// ----------------------------------------------------------------------------
module rmst_flags #(
  parameter int unsigned ENTRIES = 32,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmst_pkg::flag_cmd_e cmd_i,
  input  logic [IW-1:0]       idx_i,
  output logic [ENTRIES-1:0]  valid_o,
  output logic [ENTRIES-1:0]  removing_o,
  output logic [ENTRIES-1:0]  synced_o
);
  import rmst_pkg::*;

  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] removing_q, removing_d;
  logic [ENTRIES-1:0] synced_q, synced_d;

  always_comb begin
    valid_d    = valid_q;
    removing_d = removing_q;
    synced_d   = synced_q;
    unique case (cmd_i)
      FL_CREATE: begin
        valid_d[idx_i]    = 1'b1;
        removing_d[idx_i] = 1'b0;
        synced_d[idx_i]   = 1'b0;
      end
      FL_MARK_ADD: begin
        removing_d[idx_i] = 1'b0;
        synced_d[idx_i]   = 1'b0;
      end
      FL_MARK_REM: begin
        removing_d[idx_i] = 1'b1;
        synced_d[idx_i]   = 1'b0;
      end
      FL_DELETE: begin
        valid_d[idx_i]    = 1'b0;
        removing_d[idx_i] = 1'b0;
        synced_d[idx_i]   = 1'b0;
      end
      FL_SYNCED: begin
        synced_d[idx_i] = 1'b1;
      end
      FL_PURGE: begin
        // drop every entry that waits for a remove, forget all sync state
        valid_d    = valid_q & ~removing_q;
        removing_d = '0;
        synced_d   = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      removing_q <= '0;
      synced_q   <= '0;
    end else begin
      valid_q    <= valid_d;
      removing_q <= removing_d;
      synced_q   <= synced_d;
    end
  end

  assign valid_o    = valid_q;
  assign removing_o = removing_q;
  assign synced_o   = synced_q;

`ifndef SYNTHESIS
  a_rem_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (removing_q & ~valid_q) == '0)
    else $error("removing flag set on an empty slot");

  a_syn_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (synced_q & ~valid_q) == '0)
    else $error("synced flag set on an empty slot");

  a_purge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == FL_PURGE |=> removing_q == '0 && synced_q == '0)
    else $error("purge left removing or synced flags behind");
`endif

endmodule

### src/router_mac_sync_table.sv
// ----------------------------------------------------------------------------
// router_mac_sync_table - keyed (mac, vlan) table kept in sync with a peer
// Slot walk over a key ram with one shared key compare, flags in flip-flops.
//
//   channel   direction  handshake                 payload
//   command   in         start & !busy             opcode, key_mac, vlan,
//                                                  response_action, peer_ready
//   result    out        res_strobe_o, one cycle   req_*, status, last
//
// add, remove and sync response walk slots from 0, one slot a cycle through
// the key ram read port, until the key matches or the last slot is read.
// resync with the peer ready walks every slot; its requests come out during
// the walk. resync without the peer, mark not synced and unused opcodes skip
// the walk and go straight to apply. the final beat is shown while busy is low.
// reset clears all flags at once; no clearing pass. the receiver cannot stall.
// ----------------------------------------------------------------------------
module router_mac_sync_table #(
  parameter int unsigned ENTRIES = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 opcode_i,
  input  logic [rmst_pkg::MAC_W-1:0] key_mac_i,
  input  logic [rmst_pkg::VLAN_W-1:0] vlan_i,
  input  logic                       response_action_i,
  input  logic                       peer_ready_i,
  output logic                       res_strobe_o,
  output logic                       req_valid_o,
  output logic [rmst_pkg::MAC_W-1:0] req_mac_o,
  output logic [rmst_pkg::VLAN_W-1:0] req_vlan_o,
  output logic                       req_add_o,
  output logic [1:0]                 status_o,
  output logic                       last_o
);
  import rmst_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_RESP   = 3'd2;
  localparam logic [2:0] OP_UNSYNC = 3'd3;
  localparam logic [2:0] OP_RESYNC = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  state_e            state_q;
  logic [2:0]        op_q;
  logic [MAC_W-1:0]  mac_q;
  logic [VLAN_W-1:0] vlan_q;
  logic              resp_rem_q;
  logic              ready_q;
  logic [IW-1:0]     idx_q;
  logic [IW-1:0]     rd_idx_q;
  logic              rd_vld_q;
  logic              hit_q;
  logic [IW-1:0]     hit_idx_q;
  logic              free_q;
  logic [IW-1:0]     free_idx_q;
  logic              pend_q;
  logic [MAC_W-1:0]  pend_mac_q;
  logic [VLAN_W-1:0] pend_vlan_q;

  logic              strobe_q;
  logic              req_valid_q;
  logic [MAC_W-1:0]  req_mac_q;
  logic [VLAN_W-1:0] req_vlan_q;
  logic              req_add_q;
  logic [1:0]        status_q;
  logic              last_q;

  logic [ENTRIES-1:0] valid_v, removing_v, synced_v;
  logic [KEY_W-1:0]   rd_key;
  logic [MAC_W-1:0]   rd_mac;
  logic [VLAN_W-1:0]  rd_vlan;
  logic               slot_vld, slot_qual, key_hit, scan_end, hit_rem;

  flag_cmd_e     fl_cmd;
  logic [IW-1:0] fl_idx;
  logic          ram_we;
  logic          ap_req;
  logic          ap_add;
  logic [1:0]    ap_status;

  rmst_ram #(
    .WIDTH(KEY_W),
    .DEPTH(ENTRIES)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(free_idx_q),
    .wdata_i({mac_q, vlan_q}),
    .raddr_i(idx_q),
    .rdata_o(rd_key)
  );

  rmst_flags #(
    .ENTRIES(ENTRIES)
  ) u_flags (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (fl_cmd),
    .idx_i     (fl_idx),
    .valid_o   (valid_v),
    .removing_o(removing_v),
    .synced_o  (synced_v)
  );

  assign rd_mac  = rd_key[KEY_W-1 -: MAC_W];
  assign rd_vlan = rd_key[VLAN_W-1:0];

  // the slot whose key came back from the ram this cycle
  assign slot_vld  = valid_v[rd_idx_q];
  assign slot_qual = valid_v[rd_idx_q] & ~removing_v[rd_idx_q] & ~synced_v[rd_idx_q];
  assign key_hit   = rd_vld_q && slot_vld && (rd_mac == mac_q) && (rd_vlan == vlan_q);
  assign scan_end  = rd_vld_q && (rd_idx_q == LAST_IDX);
  assign hit_rem   = removing_v[hit_idx_q];

  always_comb begin
    fl_cmd    = FL_NONE;
    fl_idx    = hit_idx_q;
    ram_we    = 1'b0;
    ap_req    = 1'b0;
    ap_add    = 1'b0;
    ap_status = ST_OK;
    if (state_q == S_APPLY) begin
      unique case (op_q)
        OP_ADD: begin
          ap_add = 1'b1;
          if (hit_q) begin
            if (hit_rem) begin
              fl_cmd = FL_MARK_ADD;
              ap_req = ready_q;
            end
          end else if (free_q) begin
            fl_cmd = FL_CREATE;
            fl_idx = free_idx_q;
            ram_we = 1'b1;
            ap_req = ready_q;
          end else begin
            ap_status = ST_FULL;
          end
        end
        OP_REMOVE: begin
          if (hit_q && !hit_rem) begin
            fl_cmd = ready_q ? FL_MARK_REM : FL_DELETE;
            ap_req = ready_q;
          end
        end
        OP_RESP: begin
          if (!hit_q) begin
            ap_status = ST_NOTFOUND;
          end else if (hit_rem == resp_rem_q) begin
            fl_cmd = resp_rem_q ? FL_DELETE : FL_SYNCED;
          end
        end
        OP_UNSYNC: begin
          fl_cmd = FL_PURGE;
        end
        OP_RESYNC: begin
          // final request of the walk, held back until the walk ended
          ap_req = pend_q;
          ap_add = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_ADD;
      mac_q       <= '0;
      vlan_q      <= '0;
      resp_rem_q  <= 1'b0;
      ready_q     <= 1'b0;
      idx_q       <= '0;
      rd_idx_q    <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      free_q      <= 1'b0;
      free_idx_q  <= '0;
      pend_q      <= 1'b0;
      pend_mac_q  <= '0;
      pend_vlan_q <= '0;
      strobe_q    <= 1'b0;
      req_valid_q <= 1'b0;
      req_mac_q   <= '0;
      req_vlan_q  <= '0;
      req_add_q   <= 1'b0;
      status_q    <= ST_OK;
      last_q      <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          rd_vld_q <= 1'b0;
          if (start) begin
            op_q       <= opcode_i;
            mac_q      <= key_mac_i;
            vlan_q     <= vlan_i;
            resp_rem_q <= response_action_i;
            ready_q    <= peer_ready_i;
            idx_q      <= '0;
            hit_q      <= 1'b0;
            free_q     <= 1'b0;
            pend_q     <= 1'b0;
            if (opcode_i == OP_ADD || opcode_i == OP_REMOVE || opcode_i == OP_RESP ||
                (opcode_i == OP_RESYNC && peer_ready_i)) begin
              state_q <= S_SCAN;
            end else begin
              state_q <= S_APPLY;
            end
          end
        end
        S_SCAN: begin
          rd_vld_q <= 1'b1;
          rd_idx_q <= idx_q;
          if (idx_q != LAST_IDX) begin
            idx_q <= idx_q + 1'b1;
          end
          if (rd_vld_q && !slot_vld && !free_q) begin
            free_q     <= 1'b1;
            free_idx_q <= rd_idx_q;
          end
          if (op_q == OP_RESYNC) begin
            if (rd_vld_q && slot_qual) begin
              if (pend_q) begin
                strobe_q    <= 1'b1;
                req_valid_q <= 1'b1;
                req_mac_q   <= pend_mac_q;
                req_vlan_q  <= pend_vlan_q;
                req_add_q   <= 1'b1;
                status_q    <= ST_OK;
                last_q      <= 1'b0;
              end
              pend_q      <= 1'b1;
              pend_mac_q  <= rd_mac;
              pend_vlan_q <= rd_vlan;
            end
            if (scan_end) begin
              state_q <= S_APPLY;
            end
          end else if (key_hit) begin
            hit_q     <= 1'b1;
            hit_idx_q <= rd_idx_q;
            state_q   <= S_APPLY;
          end else if (scan_end) begin
            state_q <= S_APPLY;
          end
        end
        S_APPLY: begin
          rd_vld_q    <= 1'b0;
          strobe_q    <= 1'b1;
          req_valid_q <= ap_req;
          req_mac_q   <= ap_req ? ((op_q == OP_RESYNC) ? pend_mac_q : mac_q) : '0;
          req_vlan_q  <= ap_req ? ((op_q == OP_RESYNC) ? pend_vlan_q : vlan_q) : '0;
          req_add_q   <= ap_req & ap_add;
          status_q    <= ap_status;
          last_q      <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = strobe_q;
  assign req_valid_o  = req_valid_q;
  assign req_mac_o    = req_mac_q;
  assign req_vlan_o   = req_vlan_q;
  assign req_add_o    = req_add_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  a_req_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && req_valid_o |-> status_o == ST_OK)
    else $error("request beat with non-ok status");

  a_noreq_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !req_valid_o |-> req_mac_o == '0 && req_vlan_o == '0 && !req_add_o)
    else $error("non-request beat carries key bits");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && last_o |-> !busy)
    else $error("final beat while still walking");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");
`endif

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - testbench for router_mac_sync_table
// Drives add, remove, sync response, mark-not-synced, resync and unused opcode
// commands, keeps its own copy of the slot table to predict every result beat,
// and compares each strobed result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned ENTRIES = 32;

  typedef enum logic [2:0] {
    OP_ADD           = 3'd0,
    OP_REMOVE        = 3'd1,
    OP_SYNC_RESP     = 3'd2,
    OP_MARK_UNSYNCED = 3'd3,
    OP_RESYNC        = 3'd4,
    OP_RSVD5         = 3'd5,
    OP_RSVD6         = 3'd6,
    OP_RSVD7         = 3'd7
  } sync_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  localparam bit ACT_ADD    = 1'b0;
  localparam bit ACT_REMOVE = 1'b1;

  localparam logic [rmst_pkg::MAC_W-1:0]  KA_MAC  = 48'hFFFF_FFFF_FFFF;
  localparam logic [rmst_pkg::VLAN_W-1:0] KA_VLAN = 12'hFFF;
  localparam logic [rmst_pkg::MAC_W-1:0]  KB_MAC  = 48'h0000_0000_0000;
  localparam logic [rmst_pkg::VLAN_W-1:0] KB_VLAN = 12'h000;
  localparam logic [rmst_pkg::MAC_W-1:0]  KC_MAC  = 48'hAAAA_5555_AAAA;
  localparam logic [rmst_pkg::VLAN_W-1:0] KC_VLAN = 12'h555;

  typedef struct packed {
    logic                        req_valid;
    logic [rmst_pkg::MAC_W-1:0]  mac;
    logic [rmst_pkg::VLAN_W-1:0] vlan;
    logic                        add;
    logic [1:0]                  status;
    logic                        last;
  } sync_result_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        start = 1'b0;
  logic                        busy;
  logic [2:0]                  opcode_i = OP_ADD;
  logic [rmst_pkg::MAC_W-1:0]  key_mac_i = '0;
  logic [rmst_pkg::VLAN_W-1:0] vlan_i = '0;
  logic                        response_action_i = 1'b0;
  logic                        peer_ready_i = 1'b0;
  logic                        res_strobe_o;
  logic                        req_valid_o;
  logic [rmst_pkg::MAC_W-1:0]  req_mac_o;
  logic [rmst_pkg::VLAN_W-1:0] req_vlan_o;
  logic                        req_add_o;
  logic [1:0]                  status_o;
  logic                        last_o;

  // predicted slot table
  bit                          tbl_valid    [ENTRIES];
  bit [rmst_pkg::MAC_W-1:0]    tbl_mac      [ENTRIES];
  bit [rmst_pkg::VLAN_W-1:0]   tbl_vlan     [ENTRIES];
  bit                          tbl_removing [ENTRIES];
  bit                          tbl_synced   [ENTRIES];

  sync_result_t                pending_results [$];
  int                          mismatches = 0;
  bit                          no_gaps = 1'b0;
  logic [rmst_pkg::MAC_W-1:0]  pool_mac  [64];
  logic [rmst_pkg::VLAN_W-1:0] pool_vlan [64];

  router_mac_sync_table #(
    .ENTRIES(ENTRIES)
  ) uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .opcode_i          (opcode_i),
    .key_mac_i         (key_mac_i),
    .vlan_i            (vlan_i),
    .response_action_i (response_action_i),
    .peer_ready_i      (peer_ready_i),
    .res_strobe_o      (res_strobe_o),
    .req_valid_o       (req_valid_o),
    .req_mac_o         (req_mac_o),
    .req_vlan_o        (req_vlan_o),
    .req_add_o         (req_add_o),
    .status_o          (status_o),
    .last_o            (last_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic int find_key(logic [rmst_pkg::MAC_W-1:0] mac,
                                  logic [rmst_pkg::VLAN_W-1:0] vlan);
    for (int i = 0; i < ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_mac[i] == mac && tbl_vlan[i] == vlan) return i;
    end
    return -1;
  endfunction

  function automatic void drop_slot(int s);
    tbl_valid[s]    = 1'b0;
    tbl_removing[s] = 1'b0;
    tbl_synced[s]   = 1'b0;
  endfunction

  function automatic void push_result(bit req, logic [rmst_pkg::MAC_W-1:0] mac,
                                      logic [rmst_pkg::VLAN_W-1:0] vlan, bit add,
                                      status_e st, bit last);
    sync_result_t r;
    r.req_valid = req;
    r.mac       = req ? mac : '0;
    r.vlan      = req ? vlan : '0;
    r.add       = req & add;
    r.status    = st;
    r.last      = last;
    pending_results.push_back(r);
  endfunction

  function automatic void predict_table_cmd(sync_op_e op, logic [rmst_pkg::MAC_W-1:0] mac,
                                            logic [rmst_pkg::VLAN_W-1:0] vlan,
                                            bit resp_remove, bit ready);
    int hit;
    int slot;
    int sent;
    bit halted;
    hit = find_key(mac, vlan);
    case (op)
      OP_ADD: begin
        if (hit >= 0 && !tbl_removing[hit]) begin
          push_result(1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
        end else if (hit >= 0) begin
          tbl_removing[hit] = 1'b0;
          tbl_synced[hit]   = 1'b0;
          push_result(ready, mac, vlan, 1'b1, ST_OK, 1'b1);
        end else begin
          slot = -1;
          for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
          end
          if (slot < 0) begin
            push_result(1'b0, '0, '0, 1'b0, ST_FULL, 1'b1);
          end else begin
            tbl_valid[slot]    = 1'b1;
            tbl_mac[slot]      = mac;
            tbl_vlan[slot]     = vlan;
            tbl_removing[slot] = 1'b0;
            tbl_synced[slot]   = 1'b0;
            push_result(ready, mac, vlan, 1'b1, ST_OK, 1'b1);
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0 && !tbl_removing[hit]) begin
          // a peer that cannot take the request loses the entry at once
          if (ready) begin
            tbl_synced[hit]   = 1'b0;
            tbl_removing[hit] = 1'b1;
          end else begin
            drop_slot(hit);
          end
          push_result(ready, mac, vlan, 1'b0, ST_OK, 1'b1);
        end else begin
          push_result(1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_SYNC_RESP: begin
        if (hit < 0) begin
          push_result(1'b0, '0, '0, 1'b0, ST_NOT_FOUND, 1'b1);
        end else begin
          if (tbl_removing[hit] == resp_remove) begin
            if (resp_remove) drop_slot(hit);
            else tbl_synced[hit] = 1'b1;
          end
          push_result(1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
        end
      end
      OP_MARK_UNSYNCED: begin
        for (int i = 0; i < ENTRIES; i++) begin
          tbl_synced[i] = 1'b0;
          if (tbl_valid[i] && tbl_removing[i]) drop_slot(i);
        end
        push_result(1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
      end
      OP_RESYNC: begin
        sent   = 0;
        halted = 1'b0;
        // walk stops at the first pending add the peer cannot take
        for (int i = 0; i < ENTRIES; i++) begin
          if (!halted && tbl_valid[i] && !tbl_removing[i] && !tbl_synced[i]) begin
            if (!ready) begin
              halted = 1'b1;
            end else begin
              push_result(1'b1, tbl_mac[i], tbl_vlan[i], 1'b1, ST_OK, 1'b0);
              sent++;
            end
          end
        end
        if (sent == 0) push_result(1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
        else pending_results[pending_results.size() - 1].last = 1'b1;
      end
      default: begin
        push_result(1'b0, '0, '0, 1'b0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // ------------------------------------------------------------ result check

  task automatic check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // outputs are sampled mid-cycle, away from the clock edge
  always @(negedge clk_i) begin
    sync_result_t want;
    if (rst_ni && res_strobe_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual req=%0b mac=%0h",
                 $time, req_valid_o, req_mac_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("req_valid", want.req_valid, req_valid_o);
        check_field("req_mac", want.mac, req_mac_o);
        check_field("req_vlan", want.vlan, req_vlan_o);
        check_field("req_add", want.add, req_add_o);
        check_field("status", want.status, status_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // called at a rising edge, returns at the edge that accepts the beat;
  // start is left high so a back-to-back beat needs no second assignment
  task automatic send_cmd(sync_op_e op, logic [rmst_pkg::MAC_W-1:0] mac,
                          logic [rmst_pkg::VLAN_W-1:0] vlan, bit resp_remove, bit ready);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start             <= 1'b1;
    opcode_i          <= op;
    key_mac_i         <= mac;
    vlan_i            <= vlan;
    response_action_i <= resp_remove;
    peer_ready_i      <= ready;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    predict_table_cmd(op, mac, vlan, resp_remove, ready);
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // stay idle a while with nothing in flight
    repeat (ENTRIES + 4) @(posedge clk_i);
  endtask

  task automatic test_empty_table();
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b1);
    send_cmd(OP_SYNC_RESP, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_REMOVE, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_MARK_UNSYNCED, '0, '0, ACT_ADD, 1'b1);
  endtask

  task automatic test_add_remove_flow();
    send_cmd(OP_ADD, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_ADD, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);        // already marked add
    send_cmd(OP_ADD, KB_MAC, KB_VLAN, ACT_ADD, 1'b0);        // created, peer busy
    send_cmd(OP_SYNC_RESP, KA_MAC, KA_VLAN, ACT_ADD, 1'b0);
    send_cmd(OP_SYNC_RESP, KB_MAC, KB_VLAN, ACT_REMOVE, 1'b1); // wrong action
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b0);
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b1);
    send_cmd(OP_REMOVE, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_REMOVE, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);     // already removing
    send_cmd(OP_ADD, KA_MAC, KA_VLAN, ACT_ADD, 1'b0);        // re-marked add
    send_cmd(OP_REMOVE, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_SYNC_RESP, KA_MAC, KA_VLAN, ACT_REMOVE, 1'b1);
    send_cmd(OP_SYNC_RESP, KA_MAC, KA_VLAN, ACT_ADD, 1'b1);  // gone now
    send_cmd(OP_REMOVE, KB_MAC, KB_VLAN, ACT_ADD, 1'b0);
    send_cmd(OP_ADD, KC_MAC, KC_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_REMOVE, KC_MAC, KC_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_MARK_UNSYNCED, '0, '0, ACT_ADD, 1'b0);       // purges the removal
    send_cmd(OP_REMOVE, KC_MAC, KC_VLAN, ACT_ADD, 1'b1);
  endtask

  task automatic test_unused_opcodes();
    send_cmd(OP_RSVD5, KA_MAC, KA_VLAN, ACT_REMOVE, 1'b1);
    send_cmd(OP_RSVD6, KC_MAC, KC_VLAN, ACT_ADD, 1'b0);
    send_cmd(OP_RSVD7, KB_MAC, KB_VLAN, ACT_REMOVE, 1'b1);
  endtask

  task automatic test_table_full();
    logic [rmst_pkg::MAC_W-1:0] fill_mac [ENTRIES];
    for (int i = 0; i < ENTRIES; i++) begin
      fill_mac[i] = 48'({$urandom, $urandom});
      send_cmd(OP_ADD, fill_mac[i], 12'(i), ACT_ADD, 1'($urandom_range(0, 1)));
    end
    send_cmd(OP_ADD, KC_MAC, KC_VLAN, ACT_ADD, 1'b1);
    for (int i = 0; i < ENTRIES; i += 2) begin
      send_cmd(OP_SYNC_RESP, fill_mac[i], 12'(i), ACT_ADD, 1'b0);
    end
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b0);
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b1);
    send_cmd(OP_MARK_UNSYNCED, '0, '0, ACT_ADD, 1'b1);
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b1);              // every slot re-sent
    wait_results_drained();
    for (int i = 1; i < ENTRIES; i += 2) begin
      send_cmd(OP_REMOVE, fill_mac[i], 12'(i), ACT_ADD, 1'b1);
    end
    send_cmd(OP_ADD, KC_MAC, KC_VLAN, ACT_ADD, 1'b1);        // removing slots still held
    send_cmd(OP_MARK_UNSYNCED, '0, '0, ACT_ADD, 1'b0);
    send_cmd(OP_ADD, KC_MAC, KC_VLAN, ACT_ADD, 1'b1);
    send_cmd(OP_ADD, KA_MAC, KA_VLAN, ACT_ADD, 1'b0);
    send_cmd(OP_RESYNC, '0, '0, ACT_ADD, 1'b1);
    for (int i = 0; i < ENTRIES; i += 2) begin
      send_cmd(OP_REMOVE, fill_mac[i], 12'(i), ACT_ADD, 1'b0);
    end
    send_cmd(OP_REMOVE, KC_MAC, KC_VLAN, ACT_ADD, 1'b0);
    send_cmd(OP_REMOVE, KA_MAC, KA_VLAN, ACT_ADD, 1'b0);
  endtask

  task automatic test_random_traffic(int n_items, int pool_size);
    int                          k;
    int                          pick;
    int                          hit;
    sync_op_e                    op;
    logic [rmst_pkg::MAC_W-1:0]  mac;
    logic [rmst_pkg::VLAN_W-1:0] vlan;
    bit                          resp;
    for (int i = 0; i < pool_size; i++) begin
      pool_mac[i]  = 48'({$urandom, $urandom});
      pool_vlan[i] = 12'($urandom);
    end
    pool_mac[0]  = '1;
    pool_vlan[0] = '1;
    pool_mac[1]  = '0;
    pool_vlan[1] = '0;
    for (int n = 0; n < n_items; n++) begin
      if (n % 16 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      if (n == n_items / 2) wait_results_drained();
      // mostly keys from a small pool so lookups hit, now and then a fresh one
      if ($urandom_range(0, 9) == 0) begin
        mac  = 48'({$urandom, $urandom});
        vlan = 12'($urandom);
      end else begin
        k    = $urandom_range(0, pool_size - 1);
        mac  = pool_mac[k];
        vlan = pool_vlan[k];
      end
      pick = $urandom_range(0, 99);
      if (pick < 35) op = OP_ADD;
      else if (pick < 55) op = OP_REMOVE;
      else if (pick < 80) op = OP_SYNC_RESP;
      else if (pick < 86) op = OP_MARK_UNSYNCED;
      else if (pick < 95) op = OP_RESYNC;
      else op = sync_op_e'($urandom_range(5, 7));
      hit  = find_key(mac, vlan);
      resp = (hit >= 0 && $urandom_range(0, 4) != 0) ? tbl_removing[hit]
                                                      : 1'($urandom_range(0, 1));
      send_cmd(op, mac, vlan, resp, $urandom_range(0, 3) != 0);
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_add_remove_flow();
    test_unused_opcodes();
    test_table_full();
    test_random_traffic(100, 12);
    test_random_traffic(100, 40);
    wait_results_drained();
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### files.f
src/rmst_pkg.sv
src/rmst_ram.sv
src/rmst_flags.sv
src/router_mac_sync_table.sv
tb/sv/tb.sv
